// ----- design/plist_pkg.sv -----
// shared constants, codes and types of the positional list store
`default_nettype none

package plist_pkg;

	localparam int CAPACITY = 32;

	localparam int DATA_W  = 32;
	localparam int KIND_W  = 3;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 6;
	localparam int STAT_W  = 2;

	// entry index and fill count widths follow from the capacity
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// common width for position and count arithmetic
	localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PUT,
		S_RESULT,
		S_DUMP_RD,
		S_DUMP_WAIT
	} state_t;

	// request bundle from the sequencer to the entry memory
	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [DATA_W-1:0] wr_data;
	} mem_req_t;

endpackage

`default_nettype wire

// ----- design/plist_ram.sv -----
// entry memory: one write port, one read port with registered read data
`default_nettype none

module plist_ram import plist_pkg::*; (
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/plist_ctrl.sv -----
// sequencer: operation decode, shift loop over the entry memory, dump walk, result register
`default_nettype none

module plist_ctrl import plist_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic        [KIND_W-1:0] kind,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic        [POS_W-1:0]  position,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed      [DATA_W-1:0] item_value,
	output logic                          has_value,
	output logic                          last,
	output logic             [COUNT_W-1:0] entry_count,
	output logic             [STAT_W-1:0] status,
	output mem_req_t                      mem_req,
	input  wire logic        [DATA_W-1:0] mem_rd_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  rp_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] word_q;
	logic              ins_q;
	logic [STAT_W-1:0] status_q;

	logic              wv_s1;
	logic [IDX_W-1:0]  wa_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_has_q;
	logic              out_last_q;
	logic [STAT_W-1:0] out_status_q;
	logic [COUNT_W-1:0] out_count_q;

	logic              in_fire;
	logic              out_free;
	logic              out_load;
	logic [DATA_W-1:0] ld_value;
	logic              ld_has;
	logic              ld_last;
	logic [STAT_W-1:0] ld_status;
	logic              dump_last;
	logic              shift_rd;

	logic [CMP_W-1:0]  posx;
	logic [CMP_W-1:0]  lenx;
	logic [CMP_W-1:0]  idx_w;
	logic [CMP_W-1:0]  cnt_w;
	logic [CMP_W-1:0]  rp_w;
	logic              full;
	logic              empty;
	logic [STAT_W-1:0] dec_status;
	logic              dec_shift;
	logic              dec_ins;
	logic              dec_dump;
	logic [CNT_W-1:0]  len_nx;

	assign in_fire  = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign posx     = CMP_W'(position);
	assign lenx     = CMP_W'(len_q);
	assign full     = (len_q >= CNT_W'(CAPACITY));
	assign empty    = (len_q == '0);
	assign dump_last = ((CMP_W'(rp_q) + CMP_W'(1)) == lenx);

	// operation decode against the current fill count
	always_comb begin
		dec_status = ST_OK;
		dec_shift  = 1'b0;
		dec_ins    = 1'b0;
		dec_dump   = 1'b0;
		idx_w      = '0;
		len_nx     = len_q;
		case (kind)
			KIND_INS_FRONT, KIND_INS_BACK: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_shift = 1'b1;
					dec_ins   = 1'b1;
					idx_w     = (kind == KIND_INS_BACK) ? lenx : '0;
					len_nx    = len_q + CNT_W'(1);
				end
			end
			KIND_INS_AT: begin
				if (posx == '0 || posx > lenx + CMP_W'(1)) begin
					dec_status = ST_BADPOS;
				end else if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_shift = 1'b1;
					dec_ins   = 1'b1;
					idx_w     = posx - CMP_W'(1);
					len_nx    = len_q + CNT_W'(1);
				end
			end
			KIND_DEL_FRONT, KIND_DEL_BACK: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_shift = 1'b1;
					idx_w     = (kind == KIND_DEL_BACK) ? lenx - CMP_W'(1) : '0;
					len_nx    = len_q - CNT_W'(1);
				end
			end
			KIND_DEL_AT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if (posx == '0 || posx > lenx) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_shift = 1'b1;
					idx_w     = posx - CMP_W'(1);
					len_nx    = len_q - CNT_W'(1);
				end
			end
			KIND_DUMP: begin
				dec_dump = ~empty;
			end
			default: begin
			end
		endcase
		// moves and first read address of the shift loop
		if (dec_ins) begin
			cnt_w = lenx - idx_w;
			rp_w  = lenx - CMP_W'(1);
		end else begin
			cnt_w = lenx - CMP_W'(1) - idx_w;
			rp_w  = idx_w + CMP_W'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (dec_shift) begin
						state_d = S_SHIFT;
					end else if (dec_dump) begin
						state_d = S_DUMP_RD;
					end else begin
						state_d = S_RESULT;
					end
				end
			end
			S_SHIFT: begin
				if (cnt_q == '0) begin
					state_d = ins_q ? S_PUT : S_RESULT;
				end
			end
			S_PUT: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				state_d = S_DUMP_WAIT;
			end
			S_DUMP_WAIT: begin
				if (out_free) begin
					state_d = dump_last ? S_IDLE : S_DUMP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready          = 1'b0;
		shift_rd          = 1'b0;
		mem_req.rd_en     = 1'b0;
		mem_req.rd_addr   = rp_q;
		out_load          = 1'b0;
		ld_value          = '0;
		ld_has            = 1'b0;
		ld_last           = 1'b1;
		ld_status         = status_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_SHIFT: begin
				shift_rd      = (cnt_q != '0);
				mem_req.rd_en = shift_rd;
			end
			S_PUT: begin
			end
			S_RESULT: begin
				out_load = out_free;
			end
			S_DUMP_RD: begin
				mem_req.rd_en = 1'b1;
			end
			S_DUMP_WAIT: begin
				out_load  = out_free;
				ld_value  = mem_rd_data;
				ld_has    = 1'b1;
				ld_last   = dump_last;
				ld_status = ST_OK;
			end
			default: begin
			end
		endcase
		// shift writes land in the cycle after their reads; the new word goes in last
		mem_req.wr_en   = wv_s1 | (state_q == S_PUT);
		mem_req.wr_addr = wv_s1 ? wa_s1 : idx_q;
		mem_req.wr_data = wv_s1 ? mem_rd_data : word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wv_s1   <= shift_rd;
			if (in_fire) begin
				len_q <= len_nx;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q   <= value;
			idx_q    <= IDX_W'(idx_w);
			cnt_q    <= CNT_W'(cnt_w);
			rp_q     <= dec_dump ? '0 : IDX_W'(rp_w);
			ins_q    <= dec_ins;
			status_q <= dec_status;
		end else if (shift_rd) begin
			cnt_q <= cnt_q - CNT_W'(1);
			rp_q  <= ins_q ? rp_q - IDX_W'(1) : rp_q + IDX_W'(1);
		end else if (state_q == S_DUMP_WAIT && out_free) begin
			rp_q <= rp_q + IDX_W'(1);
		end
		if (shift_rd) begin
			wa_s1 <= ins_q ? rp_q + IDX_W'(1) : rp_q - IDX_W'(1);
		end
		if (out_load) begin
			out_value_q  <= ld_value;
			out_has_q    <= ld_has;
			out_last_q   <= ld_last;
			out_status_q <= ld_status;
			out_count_q  <= COUNT_W'(len_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign item_value  = $signed(out_value_q);
	assign has_value   = out_has_q;
	assign last        = out_last_q;
	assign entry_count = out_count_q;
	assign status      = out_status_q;

`ifndef SYNTH
	// fill count stays within capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// new-word write never collides with a trailing shift write
	a_put_alone: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUT |-> !wv_s1)
		else $error("put overlaps shift write");

	// shift read never hits the entry being written in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wv_s1 && shift_rd) |-> (wa_s1 != rp_q))
		else $error("shift read and write on same entry");

	// an accepted beat always leaves idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("still idle after accept");

	// final dump beat returns the sequencer to idle
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP_WAIT && out_free && dump_last) |=> state_q == S_IDLE)
		else $error("dump did not end after last beat");
`endif

endmodule

`default_nettype wire

// ----- design/positional_list_store_top.sv -----
// top level of the positional list store: sequencer plus entry memory
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   kind, value, position
//  out      source     out_valid / out_ready item_value, has_value, last, entry_count, status
//
// insert at index k: entries k to the back move up one place, one memory move per cycle,
// then the new word is written; delete moves the entries after k down; dump sends each entry
// reset clears the fill count and the control state; the entry memory is not cleared,
// entries at or beyond the fill count are never read
// the result register lets a new beat be taken while the previous result is still held
// by a stalled sink; a stalled sink holds a dump walk at its current entry
`default_nettype none

module positional_list_store_top import plist_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// operation beats
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic        [KIND_W-1:0]  kind,
	input  wire logic signed [DATA_W-1:0]  value,
	input  wire logic        [POS_W-1:0]   position,
	// result beats
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed      [DATA_W-1:0]  item_value,
	output logic                           has_value,
	output logic                           last,
	output logic             [COUNT_W-1:0] entry_count,
	output logic             [STAT_W-1:0]  status
);

	// memory request from the sequencer and registered read data back
	mem_req_t          mem_req;
	logic [DATA_W-1:0] mem_rd_data;

	// decode, shift loop, dump walk and result register
	plist_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.item_value  (item_value),
		.has_value   (has_value),
		.last        (last),
		.entry_count (entry_count),
		.status      (status),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data)
	);

	// list entries in order from the front, one read and one write per cycle
	plist_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

endmodule

`default_nettype wire
